@@ src/fpalu_pkg.sv @@
`default_nettype none
package fpalu_pkg;
   localparam int FRAC_BITS  = 8;
   localparam int WORD_W     = 32;
   localparam int NUM_W      = WORD_W + FRAC_BITS;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_COMPARE  = 4'd4,
      CMD_MIN      = 4'd5,
      CMD_MAX      = 4'd6,
      CMD_INC      = 4'd7,
      CMD_DEC      = 4'd8,
      CMD_TO_INT   = 4'd9,
      CMD_FROM_INT = 4'd10
   } cmd_type;

   typedef struct packed {
      logic [3:0]               cmd;
      logic signed [WORD_W-1:0] operand_a;
      logic signed [WORD_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     less_than;
      logic                     equal;
      logic                     greater_than;
      logic                     divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [3:0]        cmd;
      logic              neg;
      logic              dz;
      logic              lt;
      logic              eq;
      logic              gt;
      logic [WORD_W-1:0] val;
      logic [WORD_W-1:0] dvs;
      logic [WORD_W-1:0] rem;
      logic [NUM_W-1:0]  num;
   } stage_type;
endpackage
`default_nettype wire

@@ src/fixed_point_alu_q24_8_unit.sv @@
`default_nettype none
// Pipelined signed Q24.8 fixed-point ALU. One item enters per cycle unless the
// result side stalls; every opcode passes the input register, the first pipe
// register, the DIV_STAGES stages of the restoring divider, which resolves four
// quotient bits per stage over 32 + FRAC_BITS bits, and the output register.
// A stall on the result side freezes the whole pipeline and holds req_ready low.
module fixed_point_alu_q24_8_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  fpalu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output fpalu_pkg::rsp_type rsp_data
);
   localparam int W  = fpalu_pkg::WORD_W;
   localparam int NW = fpalu_pkg::NUM_W;
   localparam int NS = fpalu_pkg::DIV_STAGES;
   localparam int ST = fpalu_pkg::DIV_STEPS;
   localparam int FB = fpalu_pkg::FRAC_BITS;

   logic advance;

   // input stage
   logic                in_valid_ff;
   fpalu_pkg::req_type  in_ff;
   logic [W-1:0]        mag_a_ff, mag_b_ff;
   logic                neg_ff;

   fpalu_pkg::stage_type pipe_ff [0:NS];
   fpalu_pkg::stage_type pipe_in [0:NS];

   logic               rsp_valid_ff;
   fpalu_pkg::rsp_type rsp_ff, rsp_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_ff    <= req_data;
         mag_a_ff <= req_data.operand_a[W-1] ? W'(-req_data.operand_a) : req_data.operand_a;
         mag_b_ff <= req_data.operand_b[W-1] ? W'(-req_data.operand_b) : req_data.operand_b;
         neg_ff   <= req_data.operand_a[W-1] ^ req_data.operand_b[W-1];
      end
   end

   // multiply and simple ops
   logic [2*W-1:0] prod;
   assign prod = mag_a_ff * mag_b_ff;

   always_comb begin
      logic signed [W-1:0] a, b;
      a = in_ff.operand_a;
      b = in_ff.operand_b;
      pipe_in[0]       = '0;
      pipe_in[0].valid = in_valid_ff;
      pipe_in[0].cmd   = in_ff.cmd;
      pipe_in[0].neg   = neg_ff;
      pipe_in[0].dvs   = mag_b_ff;
      pipe_in[0].num   = {mag_a_ff, {FB{1'b0}}};
      unique case (in_ff.cmd)
         fpalu_pkg::CMD_ADD:      pipe_in[0].val = a + b;
         fpalu_pkg::CMD_SUB:      pipe_in[0].val = a - b;
         fpalu_pkg::CMD_MUL:      pipe_in[0].val = prod[FB+W-1:FB];
         fpalu_pkg::CMD_DIV:      pipe_in[0].dz  = (b == '0);
         fpalu_pkg::CMD_COMPARE: begin
            pipe_in[0].lt = a < b;
            pipe_in[0].eq = a == b;
            pipe_in[0].gt = a > b;
         end
         fpalu_pkg::CMD_MIN:      pipe_in[0].val = (a > b) ? b : a;
         fpalu_pkg::CMD_MAX:      pipe_in[0].val = (a > b) ? a : b;
         fpalu_pkg::CMD_INC:      pipe_in[0].val = a + W'(1);
         fpalu_pkg::CMD_DEC:      pipe_in[0].val = a - W'(1);
         fpalu_pkg::CMD_TO_INT:   pipe_in[0].val = a >>> FB;
         fpalu_pkg::CMD_FROM_INT: pipe_in[0].val = a << FB;
         default:                 pipe_in[0].val = '0;
      endcase
   end

   // restoring divider, DIV_STEPS quotient bits per stage
   for (genvar k = 0; k < NS; k++) begin : g_div
      always_comb begin
         logic [W-1:0]  r;
         logic [NW-1:0] n;
         logic [W:0]    t;
         logic          qb;
         r = pipe_ff[k].rem;
         n = pipe_ff[k].num;
         for (int j = 0; j < ST; j++) begin
            if (k * ST + j < NW) begin
               t = {r, n[NW-1]};
               if (t >= {1'b0, pipe_ff[k].dvs}) begin
                  t  = t - {1'b0, pipe_ff[k].dvs};
                  qb = 1'b1;
               end else begin
                  qb = 1'b0;
               end
               r = t[W-1:0];
               n = {n[NW-2:0], qb};
            end
         end
         pipe_in[k+1]     = pipe_ff[k];
         pipe_in[k+1].rem = r;
         pipe_in[k+1].num = n;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= NS; i++) begin
         if (reset) begin
            pipe_ff[i].valid <= 1'b0;
         end else if (advance) begin
            pipe_ff[i].valid <= pipe_in[i].valid;
         end
         if (advance) begin
            pipe_ff[i][$bits(fpalu_pkg::stage_type)-2:0] <=
               pipe_in[i][$bits(fpalu_pkg::stage_type)-2:0];
         end
      end
   end

   // sign fixup and final select
   always_comb begin
      fpalu_pkg::stage_type s;
      s = pipe_ff[NS];
      rsp_in.less_than      = s.lt;
      rsp_in.equal          = s.eq;
      rsp_in.greater_than   = s.gt;
      rsp_in.divide_by_zero = s.dz;
      priority if (s.cmd == fpalu_pkg::CMD_DIV) begin
         if (s.dz) begin
            rsp_in.value = '0;
         end else begin
            rsp_in.value = s.neg ? W'(-s.num[W-1:0]) : s.num[W-1:0];
         end
      end else if (s.cmd == fpalu_pkg::CMD_MUL) begin
         rsp_in.value = s.neg ? W'(-s.val) : s.val;
      end else begin
         rsp_in.value = s.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pipe_ff[NS].valid;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.value == '0)
      else $error("divide by zero with nonzero value");
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.less_than, rsp_data.equal, rsp_data.greater_than}))
      else $error("compare flags not exclusive");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pipe_ff[NS].valid) && $stable(in_valid_ff))
      else $error("pipeline moved during stall");
endmodule
`default_nettype wire

@@ bench/fixed_point_alu_q24_8_checker.sv @@
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  fpalu_pkg::req_type req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  fpalu_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 result_count
);
   fpalu_pkg::rsp_type result_queue[$];

   function automatic fpalu_pkg::rsp_type alu_predict(fpalu_pkg::req_type r);
      fpalu_pkg::rsp_type o;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] q;
      logic negative;
      o = '0;
      a = r.operand_a;
      b = r.operand_b;
      mag_a = a[31] ? 64'(-64'(signed'(a))) : 64'(a);
      mag_b = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
      negative = a[31] ^ b[31];
      case (r.cmd)
         fpalu_pkg::CMD_ADD:      o.value = a + b;
         fpalu_pkg::CMD_SUB:      o.value = a - b;
         fpalu_pkg::CMD_MUL: begin
            q = (mag_a * mag_b) >> fpalu_pkg::FRAC_BITS;
            o.value = negative ? -q[31:0] : q[31:0];
         end
         fpalu_pkg::CMD_DIV: begin
            if (b == 0) begin
               o.divide_by_zero = 1'b1;
            end else begin
               q = (mag_a << fpalu_pkg::FRAC_BITS) / mag_b;
               o.value = negative ? -q[31:0] : q[31:0];
            end
         end
         fpalu_pkg::CMD_COMPARE: begin
            o.less_than = a < b;
            o.equal = a == b;
            o.greater_than = a > b;
         end
         fpalu_pkg::CMD_MIN:      o.value = (a > b) ? b : a;
         fpalu_pkg::CMD_MAX:      o.value = (a > b) ? a : b;
         fpalu_pkg::CMD_INC:      o.value = a + 1;
         fpalu_pkg::CMD_DEC:      o.value = a - 1;
         fpalu_pkg::CMD_TO_INT:   o.value = a >>> fpalu_pkg::FRAC_BITS;
         fpalu_pkg::CMD_FROM_INT: o.value = a << fpalu_pkg::FRAC_BITS;
         default:                 o = '0;
      endcase
      return o;
   endfunction

   assign pending_count = result_queue.size();

   always @(posedge clock) begin
      fpalu_pkg::rsp_type want;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (req_valid && req_ready) result_queue.push_back(alu_predict(req_data));
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (result_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = result_queue.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ bench/fixed_point_alu_q24_8_unit_tb.sv @@
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_unit_tb;
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   fpalu_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   fpalu_pkg::rsp_type rsp_data;
   int                 fail_count;
   int                 pending_count;
   int                 result_count;
   int                 sent_count = 0;
   bit                 hold_off = 1'b0;
   bit                 calm = 1'b0;

   always #10 clock = ~clock;

   fixed_point_alu_q24_8_unit DUT (.*);

   fixed_point_alu_q24_8_checker result_checker (.*);

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(signed'($urandom_range(0, 1023)) - 512);
         3: return 32'd0;
         4: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   // leave valid high between back-to-back items; drop it only while idling
   task automatic send_item(logic [3:0] c, logic [31:0] a, logic [31:0] b);
      if (!calm) begin
         while ($urandom_range(0, 99) < 7) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: c, operand_a: a, operand_b: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off while the sender keeps going
   always @(negedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(0, 99) >= 7);
   end

   initial begin
      int cycles;
      @(posedge clock);
      while (sent_count < 400) @(posedge clock);
      @(negedge clock);
      hold_off = 1'b1;
      for (cycles = 0; cycles < 60; cycles++) @(negedge clock);
      hold_off = 1'b0;
   end

   initial begin
      logic [31:0] edge_vals[6];
      int i;
      edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h100};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (i = 0; i < 16; i++)
         send_item(i[3:0], edge_vals[i % 6], edge_vals[(i + 2) % 6]);
      send_item(fpalu_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(fpalu_pkg::CMD_DIV, 32'h0000_0100, 32'd0);
      send_item(fpalu_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
      send_item(fpalu_pkg::CMD_COMPARE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(fpalu_pkg::CMD_MIN, 32'd5, 32'd5);
      send_item(fpalu_pkg::CMD_TO_INT, 32'hFFFF_FF01, 32'd0);
      for (i = 0; i < 1730; i++) begin
         calm = (i >= 900 && i < 1150);
         send_item($urandom_range(0, 99) < 95 ? 4'($urandom_range(0, 10))
                                               : 4'($urandom_range(11, 15)),
                   pick_operand(), pick_operand());
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d items: all opcodes, unused codes, operand extremes,", sent_count);
      $display("random stalls on both sides and a long result-side hold-off");
      if (fail_count == 0) $display("fixed_point_alu_q24_8_unit_tb: clean");
      else $display("fixed_point_alu_q24_8_unit_tb: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("fixed_point_alu_q24_8_unit_tb: errors");
      $finish;
   end
endmodule
